>>> rtl/core/eqfcb_pkg.sv
// ----------------------------------------------------------------------------
// eqfcb_pkg
// Shared widths, codes and helpers of the equal-frequency calibration binner.
// ----------------------------------------------------------------------------
package eqfcb_pkg;

   localparam int SCORE_BITS     = 16;
   localparam int COUNT_BITS     = 24;
   localparam int BINS_BITS      = 16;
   localparam int MAX_DISTINCT   = 1024;
   localparam int ADDR_BITS      = $clog2(MAX_DISTINCT);
   localparam int USED_BITS      = ADDR_BITS + 1;

   // Q0.16 fraction plus one integer bit so that a full bin reads as one
   localparam int FRAC_SHIFT     = 16;
   localparam int FRAC_BITS      = FRAC_SHIFT + 1;
   localparam int NUM_BITS       = COUNT_BITS + FRAC_SHIFT;
   localparam int DIV_CNT_BITS   = $clog2(FRAC_BITS + 1);
   localparam int PROD_BITS      = COUNT_BITS + BINS_BITS;

   localparam int CSR_IDX_BITS   = 1;
   localparam int CSR_DATA_BITS  = 24;

   localparam int REQ_DATA_BITS  = ((SCORE_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = SCORE_BITS + FRAC_BITS + 2 * COUNT_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_USER_BITS  = 2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_BIN_COUNT = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TOTAL     = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COUNT,
      ST_START,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_OUT
   } state_type;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      logic [COUNT_BITS-1:0] r;
      r = (v == {COUNT_BITS{1'b1}}) ? v : v + COUNT_BITS'(1);
      return r;
   endfunction

endpackage

>>> rtl/core/equal_frequency_calibration_binner.sv
// ----------------------------------------------------------------------------
// equal_frequency_calibration_binner
// Groups a descending score stream into equal-frequency bins and reports, per
// closed bin, the median score and the rounded fraction of positive labels.
//
// Channels: req_* takes one (score, label) beat per item, tlast marking the
// end of the stream. rsp_* gives one beat per closed bin. csr_* writes
// bin_count (index 0) and total_instances (index 1) between items.
// An item that closes no bin is accepted in the idle state, then counted and
// written into the entry memory in the count state. A bin close adds a binary
// search over the entry memory (a read and a compare state per probe, up to
// 11 probes at 1024 entries) that runs alongside the restoring divider, plus
// a start and an output state, before the closing item is counted. The
// end-of-stream item flushes its bin after counting, so it may give two beats.
// One result register sits on the output: the block accepts the next item
// while a beat waits, and stalls only when a further beat is ready to load.
// Reset clears the bin state and the registers (bin_count 1, total 0); the
// entry memory needs no clearing, a fill count guards it.
// ----------------------------------------------------------------------------
module equal_frequency_calibration_binner (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata: score[15:0]
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [eqfcb_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // req_tuser: is_positive[0]
   input  logic [0:0]                           req_tuser,
   input  logic                                 req_tlast,
   // rsp_tdata: bin_median[15:0], positive_fraction[32:16],
   //            positive_items[56:33], bin_items[80:57], zero[87:81]
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [eqfcb_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   // rsp_tuser: is_final_bin[0], store_overflow[1]
   output logic [eqfcb_pkg::RSP_USER_BITS-1:0]  rsp_tuser,
   output logic                                 rsp_tlast,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [eqfcb_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [eqfcb_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import eqfcb_pkg::*;

   // entry memories
   logic [SCORE_BITS-1:0] score_mem [MAX_DISTINCT];
   logic [COUNT_BITS-1:0] count_mem [MAX_DISTINCT];

   state_type state_ff, state_in;

   // configuration
   logic [BINS_BITS-1:0]  bin_count_ff, bin_count_in;
   logic [COUNT_BITS-1:0] total_ff, total_in;

   // accepted item
   logic [SCORE_BITS-1:0] score_ff, score_in;
   logic                  pos_ff, pos_in;
   logic                  eos_ff, eos_in;
   logic                  new_entry_ff, new_entry_in;
   logic                  final_ff, final_in;

   // bin state
   logic [USED_BITS-1:0]  used_ff, used_in;
   logic [COUNT_BITS-1:0] cur_cnt_ff, cur_cnt_in;
   logic [SCORE_BITS-1:0] last_score_ff, last_score_in;
   logic [COUNT_BITS-1:0] items_ff, items_in;
   logic [COUNT_BITS-1:0] pos_cnt_ff, pos_cnt_in;
   logic [SCORE_BITS-1:0] prev_score_ff, prev_score_in;
   logic                  prev_valid_ff, prev_valid_in;
   logic                  bin_full_ff, bin_full_in;
   logic                  cmp_pend_ff, cmp_pend_in;
   logic                  overflow_ff, overflow_in;
   logic [PROD_BITS-1:0]  prod_ff, prod_in;

   // median search
   logic [USED_BITS-1:0]  lo_ff, lo_in;
   logic [USED_BITS-1:0]  hi_ff, hi_in;
   logic [ADDR_BITS-1:0]  mid_ff, mid_in;
   logic [COUNT_BITS-1:0] half_ff, half_in;
   logic [SCORE_BITS-1:0] cand_ff, cand_in;
   logic [SCORE_BITS-1:0] rd_score_ff;
   logic [COUNT_BITS-1:0] rd_cnt_ff;

   // divider
   logic [COUNT_BITS-1:0]   rem_ff, rem_in;
   logic [FRAC_BITS-1:0]    quo_ff, quo_in;
   logic [DIV_CNT_BITS-1:0] div_cnt_ff, div_cnt_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SCORE_BITS-1:0] rsp_median_ff, rsp_median_in;
   logic [FRAC_BITS-1:0]  rsp_frac_ff, rsp_frac_in;
   logic [COUNT_BITS-1:0] rsp_pos_ff, rsp_pos_in;
   logic [COUNT_BITS-1:0] rsp_items_ff, rsp_items_in;
   logic                  rsp_final_ff, rsp_final_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;
   logic                  rsp_last_ff, rsp_last_in;

   // strobes and shared terms
   logic                  req_fire, csr_fire, out_free;
   logic                  mem_we, mem_re, srch_more, div_done;
   logic                  new_entry_c, bin_full_eff, close_c;
   logic [BINS_BITS-1:0]  bins_c;
   logic                  open_c, room_c;
   logic [COUNT_BITS-1:0] entry_cnt_c, items_c;
   logic [ADDR_BITS-1:0]  wr_addr_c;
   logic [SCORE_BITS-1:0] wr_score_c;
   logic [USED_BITS:0]    mid_sum_c;
   logic [NUM_BITS-1:0]   num_c;
   logic [COUNT_BITS:0]   div_t_c;
   logic                  div_ge_c;

   // ---------------------------------------------------------------- shared terms
   always_comb begin
      bins_c       = (bin_count_ff == '0) ? BINS_BITS'(1) : bin_count_ff;
      new_entry_c  = !prev_valid_ff || (req_tdata[SCORE_BITS-1:0] < prev_score_ff);
      // full test of the last counted item is folded into the next idle cycle
      bin_full_eff = bin_full_ff | (cmp_pend_ff & (prod_ff >= PROD_BITS'(total_ff)));
      close_c      = new_entry_c & bin_full_eff;
      srch_more    = lo_ff < hi_ff;
      div_done     = (div_cnt_ff == '0);
      out_free     = !rsp_valid_ff || rsp_tready;
      mid_sum_c    = {1'b0, lo_ff} + {1'b0, hi_ff};
      num_c        = {pos_cnt_ff, FRAC_SHIFT'(0)} + NUM_BITS'(items_ff >> 1);
      div_t_c      = {rem_ff, quo_ff[FRAC_BITS-1]};
      div_ge_c     = div_t_c >= {1'b0, items_ff};

      open_c       = new_entry_ff || (used_ff == '0);
      room_c       = used_ff < USED_BITS'(MAX_DISTINCT);
      items_c      = sat_inc(items_ff);
      if (open_c && room_c) begin
         entry_cnt_c = sat_inc((used_ff == '0) ? '0 : cur_cnt_ff);
         wr_addr_c   = used_ff[ADDR_BITS-1:0];
         wr_score_c  = score_ff;
      end else begin
         // same entry, or a distinct score merged into the last entry
         entry_cnt_c = sat_inc(cur_cnt_ff);
         wr_addr_c   = ADDR_BITS'(used_ff - USED_BITS'(1));
         wr_score_c  = last_score_ff;
      end
   end

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = close_c ? ST_START : ST_COUNT;
         end
         ST_COUNT: begin
            state_in = eos_ff ? ST_START : ST_IDLE;
         end
         ST_START: begin
            state_in = ST_SRCH_RD;
         end
         ST_SRCH_RD: begin
            if (srch_more)     state_in = ST_SRCH_CMP;
            else if (div_done) state_in = ST_OUT;
         end
         ST_SRCH_CMP: begin
            state_in = ST_SRCH_RD;
         end
         ST_OUT: begin
            if (out_free) state_in = final_ff ? ST_IDLE : ST_COUNT;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- strobes
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      csr_ready  = (state_ff == ST_IDLE) && !cmp_pend_ff;
      req_fire   = req_tvalid && req_tready;
      csr_fire   = csr_valid && csr_ready;
      mem_we     = (state_ff == ST_COUNT);
      mem_re     = (state_ff == ST_SRCH_RD) && srch_more;
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      bin_count_in  = bin_count_ff;
      total_in      = total_ff;
      score_in      = score_ff;
      pos_in        = pos_ff;
      eos_in        = eos_ff;
      new_entry_in  = new_entry_ff;
      final_in      = final_ff;
      used_in       = used_ff;
      cur_cnt_in    = cur_cnt_ff;
      last_score_in = last_score_ff;
      items_in      = items_ff;
      pos_cnt_in    = pos_cnt_ff;
      prev_score_in = prev_score_ff;
      prev_valid_in = prev_valid_ff;
      bin_full_in   = bin_full_ff;
      cmp_pend_in   = cmp_pend_ff;
      overflow_in   = overflow_ff;
      prod_in       = prod_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      half_in       = half_ff;
      cand_in       = cand_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      div_cnt_in    = div_cnt_ff;
      rsp_median_in = rsp_median_ff;
      rsp_frac_in   = rsp_frac_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_items_in  = rsp_items_ff;
      rsp_final_in  = rsp_final_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      if (csr_fire) begin
         case (csr_index)
            CSR_BIN_COUNT: bin_count_in = csr_wdata[BINS_BITS-1:0];
            CSR_TOTAL:     total_in     = csr_wdata[COUNT_BITS-1:0];
            default:       ;
         endcase
      end

      // one restoring step per cycle while the divider runs
      if (!div_done) begin
         rem_in     = div_ge_c ? COUNT_BITS'(div_t_c - {1'b0, items_ff})
                               : COUNT_BITS'(div_t_c);
         quo_in     = {quo_ff[FRAC_BITS-2:0], div_ge_c};
         div_cnt_in = div_cnt_ff - DIV_CNT_BITS'(1);
      end

      case (state_ff)
         ST_IDLE: begin
            if (cmp_pend_ff) begin
               bin_full_in = bin_full_eff;
               cmp_pend_in = 1'b0;
            end
            if (req_fire) begin
               score_in     = req_tdata[SCORE_BITS-1:0];
               pos_in       = req_tuser[0];
               eos_in       = req_tlast;
               new_entry_in = new_entry_c;
               final_in     = 1'b0;
            end
         end
         ST_COUNT: begin
            if (open_c && room_c) begin
               used_in       = used_ff + USED_BITS'(1);
               last_score_in = score_ff;
            end else if (open_c) begin
               overflow_in = 1'b1;
            end
            cur_cnt_in    = entry_cnt_c;
            items_in      = items_c;
            if (pos_ff) pos_cnt_in = sat_inc(pos_cnt_ff);
            prod_in       = PROD_BITS'(items_c) * PROD_BITS'(bins_c);
            cmp_pend_in   = 1'b1;
            prev_score_in = score_ff;
            prev_valid_in = 1'b1;
            if (eos_ff) final_in = 1'b1;
         end
         ST_START: begin
            lo_in      = '0;
            hi_in      = used_ff;
            cand_in    = '0;
            half_in    = items_ff >> 1;
            rem_in     = COUNT_BITS'(num_c[NUM_BITS-1:FRAC_BITS]);
            quo_in     = num_c[FRAC_BITS-1:0];
            div_cnt_in = DIV_CNT_BITS'(FRAC_BITS);
         end
         ST_SRCH_RD: begin
            if (srch_more) mid_in = mid_sum_c[ADDR_BITS:1];
         end
         ST_SRCH_CMP: begin
            // running counts never fall, so the first match is a boundary
            if (rd_cnt_ff >= half_ff) begin
               hi_in   = {1'b0, mid_ff};
               cand_in = rd_score_ff;
            end else begin
               lo_in   = {1'b0, mid_ff} + USED_BITS'(1);
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_median_in = cand_ff;
               rsp_frac_in   = (items_ff == '0) ? '0 : quo_ff;
               rsp_pos_in    = pos_cnt_ff;
               rsp_items_in  = items_ff;
               rsp_final_in  = final_ff;
               rsp_ovf_in    = overflow_ff;
               rsp_last_in   = final_ff || !eos_ff;
               used_in       = '0;
               items_in      = '0;
               pos_cnt_in    = '0;
               bin_full_in   = 1'b0;
               cmp_pend_in   = 1'b0;
               overflow_in   = 1'b0;
               if (final_ff) begin
                  prev_score_in = '0;
                  prev_valid_in = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- memories
   always_ff @(posedge clock) begin
      if (mem_we) begin
         score_mem[wr_addr_c] <= wr_score_c;
         count_mem[wr_addr_c] <= entry_cnt_c;
      end
      if (mem_re) begin
         rd_score_ff <= score_mem[mid_sum_c[ADDR_BITS:1]];
         rd_cnt_ff   <= count_mem[mid_sum_c[ADDR_BITS:1]];
      end
   end

   // ---------------------------------------------------------------- control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         bin_count_ff  <= BINS_BITS'(1);
         total_ff      <= '0;
         used_ff       <= '0;
         items_ff      <= '0;
         pos_cnt_ff    <= '0;
         prev_score_ff <= '0;
         prev_valid_ff <= 1'b0;
         bin_full_ff   <= 1'b0;
         cmp_pend_ff   <= 1'b0;
         overflow_ff   <= 1'b0;
         div_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         bin_count_ff  <= bin_count_in;
         total_ff      <= total_in;
         used_ff       <= used_in;
         items_ff      <= items_in;
         pos_cnt_ff    <= pos_cnt_in;
         prev_score_ff <= prev_score_in;
         prev_valid_ff <= prev_valid_in;
         bin_full_ff   <= bin_full_in;
         cmp_pend_ff   <= cmp_pend_in;
         overflow_ff   <= overflow_in;
         div_cnt_ff    <= div_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------- payload registers
   always_ff @(posedge clock) begin
      score_ff      <= score_in;
      pos_ff        <= pos_in;
      eos_ff        <= eos_in;
      new_entry_ff  <= new_entry_in;
      final_ff      <= final_in;
      cur_cnt_ff    <= cur_cnt_in;
      last_score_ff <= last_score_in;
      prod_ff       <= prod_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      half_ff       <= half_in;
      cand_ff       <= cand_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      rsp_median_ff <= rsp_median_in;
      rsp_frac_ff   <= rsp_frac_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_items_ff  <= rsp_items_in;
      rsp_final_ff  <= rsp_final_in;
      rsp_ovf_ff    <= rsp_ovf_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // ---------------------------------------------------------------- result port
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({rsp_items_ff, rsp_pos_ff, rsp_frac_ff, rsp_median_ff});
   assign rsp_tuser  = {rsp_ovf_ff, rsp_final_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> dv/equal_frequency_calibration_binner_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// equal_frequency_calibration_binner_tb
// Drives descending score streams into the binner and checks every closed-bin
// beat against an in-bench prediction of the bin's median, counts and flags
// and its rounded positive fraction. The test tasks cover reset values,
// extreme fields and registers, zero bin count, unsorted items and store
// overflow. Random streams then run under several idle and stall mixes.
// ----------------------------------------------------------------------------
module equal_frequency_calibration_binner_tb;
   import eqfcb_pkg::*;

   localparam int LIMIT_CYCLES = 1_000_000;
   localparam int DRAIN_CYCLES = 60;

   typedef struct {
      logic [SCORE_BITS-1:0] median;
      logic [FRAC_BITS-1:0]  fraction;
      logic [COUNT_BITS-1:0] pos_items;
      logic [COUNT_BITS-1:0] items;
      bit                    final_bin;
      bit                    overflow;
      bit                    last;
   } bin_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_BITS-1:0]  req_tdata = '0;
   logic [0:0]                req_tuser = '0;
   logic                      req_tlast = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic [RSP_USER_BITS-1:0]  rsp_tuser;
   logic                      rsp_tlast;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_BITS-1:0]   csr_index = CSR_BIN_COUNT;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   equal_frequency_calibration_binner dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // --- bin predictor state ---
   logic [BINS_BITS-1:0]  cfg_bin_count = 16'd1;
   logic [COUNT_BITS-1:0] cfg_total     = '0;
   logic [SCORE_BITS-1:0] entry_score   [MAX_DISTINCT];
   logic [COUNT_BITS-1:0] entry_running [MAX_DISTINCT];
   int unsigned           used_entries  = 0;
   logic [COUNT_BITS-1:0] bin_items     = '0;
   logic [COUNT_BITS-1:0] bin_pos       = '0;
   logic [COUNT_BITS-1:0] bin_neg       = '0;
   logic [SCORE_BITS-1:0] prev_score    = '0;
   bit                    prev_valid    = 1'b0;
   bit                    bin_full      = 1'b0;
   bit                    bin_overflow  = 1'b0;

   bin_result_type pending_bins[$];
   int          error_count    = 0;
   int          items_sent     = 0;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;

   function automatic logic [COUNT_BITS-1:0] count_up(input logic [COUNT_BITS-1:0] v);
      return (v == {COUNT_BITS{1'b1}}) ? v : v + 1'b1;
   endfunction

   function automatic void clear_open_bin();
      used_entries = 0;
      bin_items    = '0;
      bin_pos      = '0;
      bin_neg      = '0;
      bin_full     = 1'b0;
      bin_overflow = 1'b0;
   endfunction

   function automatic void open_store_entry(input logic [SCORE_BITS-1:0] score);
      if (used_entries < MAX_DISTINCT) begin
         entry_score[used_entries]   = score;
         entry_running[used_entries] = (used_entries > 0) ? entry_running[used_entries-1] : '0;
         used_entries++;
      end else begin
         // distinct score past the store: merges into the last entry
         bin_overflow = 1'b1;
      end
   endfunction

   function automatic void queue_bin_result(input bit final_bin, input bit last);
      bin_result_type  r;
      longint unsigned half;
      longint unsigned frac;
      half = longint'(bin_items) / 2;
      r.median = '0;
      for (int i = 0; i < used_entries; i++) begin
         if (entry_running[i] >= half) begin
            r.median = entry_score[i];
            break;
         end
      end
      frac = 0;
      if (bin_items != 0)
         frac = (longint'(bin_pos) * 65536 + bin_items / 2) / bin_items;
      r.fraction  = frac[FRAC_BITS-1:0];
      r.pos_items = bin_pos;
      r.items     = bin_items;
      r.final_bin = final_bin;
      r.overflow  = bin_overflow;
      r.last      = last;
      pending_bins.push_back(r);
   endfunction

   function automatic void predict_bins(input logic [SCORE_BITS-1:0] score,
                                        input bit positive, input bit eos);
      longint unsigned divisor;
      longint unsigned threshold;
      divisor   = (cfg_bin_count == '0) ? 64'd1 : 64'(cfg_bin_count);
      threshold = (longint'(cfg_total) + divisor - 1) / divisor;
      if (!prev_valid || score < prev_score) begin
         if (bin_full) begin
            queue_bin_result(1'b0, !eos);
            clear_open_bin();
         end
         open_store_entry(score);
      end else if (used_entries == 0) begin
         open_store_entry(score);
      end
      if (positive)
         bin_pos = count_up(bin_pos);
      else
         bin_neg = count_up(bin_neg);
      bin_items = count_up(bin_items);
      entry_running[used_entries-1] = count_up(entry_running[used_entries-1]);
      if (bin_items >= threshold)
         bin_full = 1'b1;
      prev_score = score;
      prev_valid = 1'b1;
      if (eos) begin
         queue_bin_result(1'b1, 1'b1);
         clear_open_bin();
         prev_score = '0;
         prev_valid = 1'b0;
      end
   endfunction

   // --- drivers ---
   // valid stays high after a beat; an idle gap in the next call or a drain lowers it
   task automatic send_score(input logic [SCORE_BITS-1:0] score, input bit positive,
                             input bit eos);
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= score;
      req_tuser  <= positive;
      req_tlast  <= eos;
      do @(posedge clock); while (!req_tready);
      predict_bins(score, positive, eos);
      items_sent++;
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (pending_bins.size() != 0) @(posedge clock);
      // an item that closes nothing may still be in flight
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_bins(input logic [CSR_DATA_BITS-1:0] bin_word,
                               input logic [CSR_DATA_BITS-1:0] total_word);
      csr_valid <= 1'b1;
      csr_index <= CSR_BIN_COUNT;
      csr_wdata <= bin_word;
      do @(posedge clock); while (!csr_ready);
      cfg_bin_count = bin_word[BINS_BITS-1:0];
      csr_index <= CSR_TOTAL;
      csr_wdata <= total_word;
      do @(posedge clock); while (!csr_ready);
      cfg_total = total_word;
      csr_valid <= 1'b0;
   endtask

   // --- result checking ---
   task automatic check_field(input string field, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      bin_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_bins.size() == 0) begin
            $display("%0t: unexpected bin beat expected none actual %h", $time, rsp_tdata);
            error_count++;
         end else begin
            want = pending_bins.pop_front();
            check_field("bin_median", 64'(want.median), 64'(rsp_tdata[15:0]));
            check_field("positive_fraction", 64'(want.fraction), 64'(rsp_tdata[32:16]));
            check_field("positive_items", 64'(want.pos_items), 64'(rsp_tdata[56:33]));
            check_field("bin_items", 64'(want.items), 64'(rsp_tdata[80:57]));
            check_field("is_final_bin", 64'(want.final_bin), 64'(rsp_tuser[0]));
            check_field("store_overflow", 64'(want.overflow), 64'(rsp_tuser[1]));
            check_field("last_in_run", 64'(want.last), 64'(rsp_tlast));
         end
      end
      rsp_tready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // --- tests ---
   // reset values: one bin, zero total, so every item leaves the bin full
   task automatic test_default_config();
      send_score(16'd100, 1'b1, 1'b0);
      send_score(16'd100, 1'b0, 1'b0);
      send_score(16'd50, 1'b1, 1'b1);
      send_score(16'd7, 1'b0, 1'b1);
   endtask

   task automatic test_field_extremes();
      wait_drain();
      program_bins(24'h00FFFF, 24'hFFFFFF);
      send_score(16'hFFFF, 1'b1, 1'b0);
      send_score(16'hFFFF, 1'b0, 1'b0);
      send_score(16'h0000, 1'b1, 1'b1);
      // all positive reads as one
      send_score(16'd40000, 1'b1, 1'b0);
      send_score(16'd30000, 1'b1, 1'b0);
      send_score(16'd20000, 1'b1, 1'b1);
      // median walk lands on a zero score
      send_score(16'd5, 1'b0, 1'b0);
      send_score(16'd0, 1'b0, 1'b0);
      send_score(16'd0, 1'b1, 1'b0);
      send_score(16'd0, 1'b0, 1'b1);
   endtask

   task automatic test_zero_bin_count();
      wait_drain();
      program_bins(24'hAB0000, 24'd4);
      send_score(16'd900, 1'b1, 1'b0);
      send_score(16'd900, 1'b1, 1'b0);
      send_score(16'd800, 1'b0, 1'b0);
      send_score(16'd800, 1'b0, 1'b0);
      send_score(16'd800, 1'b1, 1'b0);
      send_score(16'd10, 1'b0, 1'b1);
   endtask

   // unsorted item joins the open entry and closes nothing
   task automatic test_rising_score();
      wait_drain();
      program_bins(24'd2, 24'd4);
      send_score(16'd500, 1'b1, 1'b0);
      send_score(16'd400, 1'b0, 1'b0);
      send_score(16'd900, 1'b1, 1'b0);
      send_score(16'd300, 1'b0, 1'b1);
   endtask

   task automatic test_pause_mid_stream();
      send_score(16'd900, 1'b1, 1'b0);
      send_score(16'd800, 1'b0, 1'b0);
      send_score(16'd700, 1'b1, 1'b0);
      wait_drain();
      send_score(16'd600, 1'b1, 1'b1);
   endtask

   // more distinct scores than the store holds, then a close and a flush
   task automatic test_store_overflow();
      wait_drain();
      program_bins(24'd1, CSR_DATA_BITS'(MAX_DISTINCT + 6));
      for (int i = 0; i < MAX_DISTINCT + 6; i++)
         send_score(SCORE_BITS'(16'hFFFF - i * 60), 1'($urandom_range(0, 1)), 1'b0);
      send_score(16'd100, 1'b1, 1'b0);
      send_score(16'd100, 1'b0, 1'b0);
      send_score(16'd0, 1'b1, 1'b1);
   endtask

   task automatic send_random_stream(input bit force_config);
      int                       len;
      int                       pick;
      int                       label_mode;
      int unsigned              level;
      int unsigned              drop;
      logic [CSR_DATA_BITS-1:0] bin_word;
      logic [CSR_DATA_BITS-1:0] total_word;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
      if (force_config || $urandom_range(0, 9) < 4) begin
         case ($urandom_range(0, 9))
            0:       bin_word = '0;
            1:       bin_word = 24'h00FFFF;
            2:       bin_word = 24'd1;
            3:       bin_word = CSR_DATA_BITS'($urandom_range(0, 65535));
            default: bin_word = CSR_DATA_BITS'($urandom_range(2, 8));
         endcase
         bin_word[23:16] = 8'($urandom_range(0, 255));
         case ($urandom_range(0, 9))
            0:       total_word = '0;
            1:       total_word = 24'hFFFFFF;
            2:       total_word = CSR_DATA_BITS'($urandom_range(0, 24'hFFFFFF));
            default: total_word = CSR_DATA_BITS'($urandom_range(0, 2 * len));
         endcase
         wait_drain();
         program_bins(bin_word, total_word);
      end
      label_mode = $urandom_range(0, 9);
      case ($urandom_range(0, 9))
         0:       level = $urandom_range(0, 40);
         1:       level = 65535;
         default: level = $urandom_range(0, 65535);
      endcase
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 4 && level < 65535) begin
            level = level + $urandom_range(1, 65535 - level);
         end else if (pick >= 45) begin
            drop  = $urandom_range(1, (pick < 80) ? 64 : 4000);
            level = (level > drop) ? level - drop : 0;
         end
         send_score(level[15:0],
                    (label_mode == 0) ? 1'b0 :
                    (label_mode == 1) ? 1'b1 : 1'($urandom_range(0, 1)),
                    i == len - 1);
      end
   endtask

   task automatic test_random_streams(input int target, input int idle_pct,
                                      input int stall_pct);
      int first;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      first = items_sent;
      send_random_stream(1'b1);
      while (items_sent - first < target)
         send_random_stream(1'b0);
   endtask

   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("equal_frequency_calibration_binner: mismatch");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_config();
      test_field_extremes();
      test_zero_bin_count();
      test_rising_score();
      test_pause_mid_stream();
      test_store_overflow();
      test_random_streams(110, 0, 0);
      test_random_streams(110, 50, 0);
      test_random_streams(110, 0, 50);
      test_random_streams(110, 10, 10);
      wait_drain();
      if (pending_bins.size() != 0) begin
         $display("%0t: %0d bin beats expected but never seen", $time, pending_bins.size());
         error_count++;
      end
      if (error_count == 0)
         $display("equal_frequency_calibration_binner: match");
      else
         $display("equal_frequency_calibration_binner: mismatch");
      $finish;
   end

endmodule

>>> files.f
rtl/core/eqfcb_pkg.sv
rtl/core/equal_frequency_calibration_binner.sv
dv/equal_frequency_calibration_binner_tb.sv
